// ----- src/rgb_hsv_color_gate_assert.svh -----
// Assertion shorthands for the color gate. Both sample on clk and stand down in reset.
`ifndef RGB_HSV_COLOR_GATE_ASSERT_SVH
`define RGB_HSV_COLOR_GATE_ASSERT_SVH

// Same-cycle implication.
`define RHC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define RHC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/rhc_pkg.sv -----
`timescale 1ns / 1ps
package rhc_pkg;

	localparam int CH_W   = 8;
	localparam int Q_W    = 12;  // Q8.4 quotient width
	localparam int NUM_W  = 20;  // dividend width, 2880*255 and 4080*255 both fit
	localparam int STEP_N = 12;  // one quotient bit per cell

	localparam logic [Q_W-1:0] HUE_FULL = 12'd2880;  // 360 degrees in half-degree Q8.4
	localparam logic [Q_W-1:0] SAT_FULL = 12'd4080;  // 255.0 in Q8.4

	// config register map
	localparam logic [1:0] CFG_HUE_MIN = 2'd0;
	localparam logic [1:0] CFG_HUE_MAX = 2'd1;
	localparam logic [1:0] CFG_SAT_MIN = 2'd2;
	localparam logic [1:0] CFG_SAT_MAX = 2'd3;

	localparam logic [CH_W-1:0] HUE_MIN_RST = 8'd90;
	localparam logic [CH_W-1:0] HUE_MAX_RST = 8'd180;
	localparam logic [CH_W-1:0] SAT_MIN_RST = 8'd40;
	localparam logic [CH_W-1:0] SAT_MAX_RST = 8'd90;

	typedef struct packed {
		logic [CH_W-1:0] hue_min;
		logic [CH_W-1:0] hue_max;
		logic [CH_W-1:0] sat_min;
		logic [CH_W-1:0] sat_max;
	} lim_t;

	// word handed from cell to cell: two restoring dividers side by side
	typedef struct packed {
		logic [NUM_W-1:0] rem_h;
		logic [CH_W-1:0]  div_h;
		logic [Q_W-1:0]   q_h;
		logic [NUM_W-1:0] rem_s;
		logic [CH_W-1:0]  div_s;
		logic [Q_W-1:0]   q_s;
		logic [CH_W-1:0]  v;
		logic             last;
	} div_t;

endpackage

// ----- src/rhc_if.sv -----
`timescale 1ns / 1ps
interface rhc_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic       last_of_cloud;

	modport source (output valid, red, green, blue, last_of_cloud, input ready);
	modport sink   (input valid, red, green, blue, last_of_cloud, output ready);
endinterface

interface rhc_hsv_if;
	logic        valid;
	logic        ready;
	logic [11:0] hue;
	logic [11:0] saturation;
	logic [7:0]  brightness;
	logic        keep;
	logic        last_out;

	modport source (output valid, hue, saturation, brightness, keep, last_out, input ready);
	modport sink   (input valid, hue, saturation, brightness, keep, last_out, output ready);
endinterface

// ----- src/rgb_hsv_color_gate.sv -----
`timescale 1ns / 1ps
// channel | dir | payload                                        | handshake
// pix     | in  | red, green, blue [8], last_of_cloud [1]          | valid/ready
// hsv     | out | hue [12], saturation [12], brightness [8],       | valid/ready
//         |     | keep [1], last_out [1]                          |
// cfg     | in  | cfg_index [2], cfg_data [8]                     | cfg_en, no stall
//
// One word per clock sustained while hsv takes every word. From pix accept to hsv valid a word passes
// three prep stages, twelve divider cells (one quotient bit each) and one output register.
// Every stage holds its own valid bit, so bubbles close up and pix stays ready while a result
// waits on hsv, as long as some stage is empty. A stall on hsv backs up stage by stage.
// arst_n clears all valid bits and loads the window limits with their defaults.
module rgb_hsv_color_gate import rhc_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	rhc_pix_if.sink         pix,
	rhc_hsv_if.source       hsv,
	input  logic            cfg_en,
	input  logic [1:0]      cfg_index,
	input  logic [CH_W-1:0] cfg_data
);

	lim_t lim_q;

	// cell chain plumbing: slot 0 is the prep output, slot STEP_N feeds the output register
	logic vld_c [STEP_N+1];
	logic rdy_c [STEP_N+1];
	div_t word_c [STEP_N+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q.hue_min <= HUE_MIN_RST;
			lim_q.hue_max <= HUE_MAX_RST;
			lim_q.sat_min <= SAT_MIN_RST;
			lim_q.sat_max <= SAT_MAX_RST;
		end else if (cfg_en) begin
			case (cfg_index)
				CFG_HUE_MIN: lim_q.hue_min <= cfg_data;
				CFG_HUE_MAX: lim_q.hue_max <= cfg_data;
				CFG_SAT_MIN: lim_q.sat_min <= cfg_data;
				CFG_SAT_MAX: lim_q.sat_max <= cfg_data;
				default: ;
			endcase
		end
	end

	// V, spread, hue numerator with sector offset and wrap, saturation numerator
	rhc_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pix.valid),
		.in_ready  (pix.ready),
		.red       (pix.red),
		.green     (pix.green),
		.blue      (pix.blue),
		.last_in   (pix.last_of_cloud),
		.out_valid (vld_c[0]),
		.out_ready (rdy_c[0]),
		.out_data  (word_c[0])
	);

	// quotient bits MSB first: cell i resolves bit STEP_N-1-i of hue and saturation
	for (genvar i = 0; i < STEP_N; i++) begin : g_cell
		rhc_cell #(.SHIFT(STEP_N - 1 - i)) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (vld_c[i]),
			.in_ready  (rdy_c[i]),
			.in_data   (word_c[i]),
			.out_valid (vld_c[i+1]),
			.out_ready (rdy_c[i+1]),
			.out_data  (word_c[i+1])
		);
	end

	// window test and output register
	rhc_gate u_gate (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_c[STEP_N]),
		.in_ready (rdy_c[STEP_N]),
		.in_data  (word_c[STEP_N]),
		.lim      (lim_q),
		.hsv      (hsv)
	);

	`include "rgb_hsv_color_gate_assert.svh"

	// black pixel must leave the dividers as zero
	`RHC_ASSERT_NOW(a_black_zero, hsv.valid && hsv.brightness == '0, hsv.saturation == '0 && hsv.hue == '0, "black pixel with nonzero hue or saturation")
	// hue quotient stays below a full turn
	`RHC_ASSERT_NOW(a_hue_range, hsv.valid, hsv.hue < HUE_FULL, "hue quotient out of range")
	// saturation quotient never above full scale
	`RHC_ASSERT_NOW(a_sat_range, hsv.valid, hsv.saturation <= SAT_FULL, "saturation quotient out of range")
	// a kept word sits inside the saturation window of the limits in force
	`RHC_ASSERT_NOW(a_keep_sat, hsv.valid && hsv.keep, hsv.saturation >= {lim_q.sat_min, 4'b0} && hsv.saturation <= {lim_q.sat_max, 4'b0}, "kept word outside saturation window")

endmodule

// ----- src/rhc_prep.sv -----
`timescale 1ns / 1ps
module rhc_prep import rhc_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [CH_W-1:0] red,
	input  logic [CH_W-1:0] green,
	input  logic [CH_W-1:0] blue,
	input  logic            last_in,
	output logic            out_valid,
	input  logic            out_ready,
	output div_t            out_data
);

	typedef enum logic [1:0] {SEL_R, SEL_G, SEL_B} sel_t;

	typedef struct packed {
		logic [CH_W-1:0] v;
		logic [CH_W-1:0] d;
		sel_t            sel;
		logic [8:0]      diff;  // two's complement
		logic            last;
	} sa_t;

	typedef struct packed {
		logic [CH_W-1:0]  v;
		logic [CH_W-1:0]  d;
		logic [20:0]      term;  // signed hue numerator before wrap
		logic [NUM_W-1:0] wrap;
		logic             last;
	} sb_t;

	logic vld_s1, vld_s2, vld_s3;
	logic rdy_s1, rdy_s2, rdy_s3;
	sa_t  a_d, a_s1;
	sb_t  b_d, b_s2;
	div_t c_d, c_s3;

	logic [CH_W-1:0] mn;
	logic [20:0]     diff_x, d_x;

	assign rdy_s3   = !vld_s3 || out_ready;
	assign rdy_s2   = !vld_s2 || rdy_s3;
	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	// max with red > green > blue on ties, spread and the signed difference term
	always_comb begin
		mn = (red < green) ? red : green;
		mn = (mn < blue) ? mn : blue;
		a_d.last = last_in;
		if (red >= green && red >= blue) begin
			a_d.v    = red;
			a_d.sel  = SEL_R;
			a_d.diff = {1'b0, green} - {1'b0, blue};
		end else if (green >= blue) begin
			a_d.v    = green;
			a_d.sel  = SEL_G;
			a_d.diff = {1'b0, blue} - {1'b0, red};
		end else begin
			a_d.v    = blue;
			a_d.sel  = SEL_B;
			a_d.diff = {1'b0, red} - {1'b0, green};
		end
		a_d.d = a_d.v - mn;
	end

	// sector offset plus 480*diff, modulo 2^21
	always_comb begin
		diff_x    = {{12{a_s1.diff[8]}}, a_s1.diff};
		d_x       = 21'(a_s1.d);
		b_d.v     = a_s1.v;
		b_d.d     = a_s1.d;
		b_d.last  = a_s1.last;
		b_d.wrap  = NUM_W'(a_s1.d) * NUM_W'(2880);
		case (a_s1.sel)
			SEL_R:   b_d.term = diff_x * 21'd480;
			SEL_G:   b_d.term = d_x * 21'd960 + diff_x * 21'd480;
			SEL_B:   b_d.term = d_x * 21'd1920 + diff_x * 21'd480;
			default: b_d.term = '0;
		endcase
	end

	// wrap negative hue, load the dividers; zero divisors become one over a zero dividend
	always_comb begin
		c_d.rem_h = b_s2.term[20] ? (b_s2.term[NUM_W-1:0] + b_s2.wrap) : b_s2.term[NUM_W-1:0];
		c_d.div_h = (b_s2.d == '0) ? CH_W'(1) : b_s2.d;
		c_d.q_h   = '0;
		c_d.rem_s = NUM_W'(b_s2.d) * NUM_W'(4080);
		c_d.div_s = (b_s2.v == '0) ? CH_W'(1) : b_s2.v;
		c_d.q_s   = '0;
		c_d.v     = b_s2.v;
		c_d.last  = b_s2.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= in_valid;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) a_s1 <= a_d;
		if (rdy_s2 && vld_s1)   b_s2 <= b_d;
		if (rdy_s3 && vld_s2)   c_s3 <= c_d;
	end

	assign out_valid = vld_s3;
	assign out_data  = c_s3;

endmodule

// ----- src/rhc_cell.sv -----
`timescale 1ns / 1ps
module rhc_cell import rhc_pkg::*; #(
	parameter int SHIFT = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  div_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output div_t out_data
);

	logic             vld_q;
	div_t             nxt, word_q;
	logic [NUM_W-1:0] sh_h, sh_s;

	assign in_ready = !vld_q || out_ready;

	// one restoring step on quotient bit SHIFT, both dividers
	always_comb begin
		nxt  = in_data;
		sh_h = NUM_W'(in_data.div_h) << SHIFT;
		sh_s = NUM_W'(in_data.div_s) << SHIFT;
		if (in_data.rem_h >= sh_h) begin
			nxt.rem_h      = in_data.rem_h - sh_h;
			nxt.q_h[SHIFT] = 1'b1;
		end
		if (in_data.rem_s >= sh_s) begin
			nxt.rem_s      = in_data.rem_s - sh_s;
			nxt.q_s[SHIFT] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (in_ready) begin
			vld_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) word_q <= nxt;
	end

	assign out_valid = vld_q;
	assign out_data  = word_q;

endmodule

// ----- src/rhc_gate.sv -----
`timescale 1ns / 1ps
module rhc_gate import rhc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  div_t       in_data,
	input  lim_t       lim,
	rhc_hsv_if.source  hsv
);

	logic            vld_q;
	logic [Q_W-1:0]  hue_q, sat_q;
	logic [CH_W-1:0] v_q;
	logic            keep_q, last_q;
	logic            keep_d;

	assign in_ready = !vld_q || hsv.ready;

	// limits scaled to Q8.4
	assign keep_d = (in_data.q_h >= {lim.hue_min, 4'b0}) && (in_data.q_h <= {lim.hue_max, 4'b0})
		&& (in_data.q_s >= {lim.sat_min, 4'b0}) && (in_data.q_s <= {lim.sat_max, 4'b0});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (in_ready) begin
			vld_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			hue_q  <= in_data.q_h;
			sat_q  <= in_data.q_s;
			v_q    <= in_data.v;
			keep_q <= keep_d;
			last_q <= in_data.last;
		end
	end

	assign hsv.valid      = vld_q;
	assign hsv.hue        = hue_q;
	assign hsv.saturation = sat_q;
	assign hsv.brightness = v_q;
	assign hsv.keep       = keep_q;
	assign hsv.last_out   = last_q;

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
	import rhc_pkg::*;

	localparam int PERIOD      = 20;
	localparam int SETTLE      = 20;    // > pipeline latency
	localparam int STALL_LIMIT = 1000;  // cycles with no word moved on either side
	localparam int PHASES      = 9;
	localparam int PER_PHASE   = 148;   // random pixels per window setting
	localparam int N_DIRECTED  = 21;

	// one hsv word as the checker sees it
	typedef struct packed {
		logic [Q_W-1:0]  hue;
		logic [Q_W-1:0]  sat;
		logic [CH_W-1:0] bright;
		logic            keep;
		logic            last;
	} hsv_word_t;

	// directed row; hue/sat/bright/keep only meaningful when typed is set
	typedef struct packed {
		logic [7:0]  r;
		logic [7:0]  g;
		logic [7:0]  b;
		logic        last;
		logic        typed;
		logic [11:0] hue;
		logic [11:0] sat;
		logic [7:0]  bright;
		logic        keep;
	} pixel_case_t;

	logic clk;
	logic arst_n;
	logic cfg_en;
	logic [1:0] cfg_index;
	logic [CH_W-1:0] cfg_data;

	rhc_pix_if pix_bus ();
	rhc_hsv_if hsv_bus ();

	rgb_hsv_color_gate uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix       (pix_bus),
		.hsv       (hsv_bus),
		.cfg_en    (cfg_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// local copy of the window registers, reset values
	int lim_hue_min = 90;
	int lim_hue_max = 180;
	int lim_sat_min = 40;
	int lim_sat_max = 90;

	hsv_word_t pending_hsv[$];  // words still owed by the block, oldest first
	int fail_count  = 0;
	int stall_count = 0;
	bit calm        = 0;        // no idling on either side while set

	// Directed rows. Typed rows are at reset limits (hue 90..180, sat 40..90),
	// so all of them land outside the window.
	pixel_case_t directed_cases [0:N_DIRECTED-1] = '{
		// r     g      b      last  typ  hue       sat       bright  keep
		'{8'd0,   8'd0,   8'd0,   1'b0, 1'b1, 12'd0,    12'd0,    8'd0,   1'b0}, // black
		'{8'd255, 8'd255, 8'd255, 1'b0, 1'b1, 12'd0,    12'd0,    8'd255, 1'b0}, // white
		'{8'd255, 8'd0,   8'd0,   1'b0, 1'b1, 12'd0,    12'd4080, 8'd255, 1'b0}, // pure red
		'{8'd0,   8'd255, 8'd0,   1'b0, 1'b1, 12'd960,  12'd4080, 8'd255, 1'b0}, // pure green
		'{8'd0,   8'd0,   8'd255, 1'b1, 1'b1, 12'd1920, 12'd4080, 8'd255, 1'b0}, // pure blue
		'{8'd128, 8'd128, 8'd128, 1'b0, 1'b1, 12'd0,    12'd0,    8'd128, 1'b0}, // mid gray
		'{8'd1,   8'd0,   8'd0,   1'b0, 1'b1, 12'd0,    12'd4080, 8'd1,   1'b0}, // tiny V
		'{8'd255, 8'd255, 8'd0,   1'b0, 1'b0, '0, '0, '0, 1'b0}, // red/green tie
		'{8'd0,   8'd200, 8'd200, 1'b0, 1'b0, '0, '0, '0, 1'b0}, // green/blue tie
		'{8'd200, 8'd0,   8'd200, 1'b0, 1'b0, '0, '0, '0, 1'b0}, // red/blue tie
		'{8'd255, 8'd0,   8'd1,   1'b0, 1'b0, '0, '0, '0, 1'b0}, // wrap, hue near top
		'{8'd255, 8'd0,   8'd10,  1'b0, 1'b0, '0, '0, '0, 1'b0}, // wrap
		'{8'd10,  8'd0,   8'd255, 1'b0, 1'b0, '0, '0, '0, 1'b0},
		'{8'd0,   8'd10,  8'd255, 1'b0, 1'b0, '0, '0, '0, 1'b0},
		'{8'd255, 8'd254, 8'd254, 1'b0, 1'b0, '0, '0, '0, 1'b0}, // d = 1, large V
		'{8'd100, 8'd110, 8'd130, 1'b0, 1'b0, '0, '0, '0, 1'b0}, // inside reset window
		'{8'd60,  8'd120, 8'd110, 1'b0, 1'b0, '0, '0, '0, 1'b0},
		'{8'd1,   8'd1,   8'd0,   1'b0, 1'b0, '0, '0, '0, 1'b0},
		'{8'd0,   8'd1,   8'd1,   1'b0, 1'b0, '0, '0, '0, 1'b0},
		'{8'd170, 8'd85,  8'd255, 1'b1, 1'b0, '0, '0, '0, 1'b0},
		'{8'd85,  8'd170, 8'd255, 1'b0, 1'b0, '0, '0, '0, 1'b0}
	};

	initial begin
		clk = 1'b0;
		forever #(PERIOD / 2) clk = ~clk;
	end

	// HSV prediction, exact integer form of the conversion.
	// Hue numerator is degrees*8*d; negatives wrap by 360 degrees (2880*d).
	function automatic hsv_word_t predict_hsv(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b, input logic last);
		int ri, gi, bi, vmax, vmin, d, num;
		hsv_word_t w;
		ri = int'(r);
		gi = int'(g);
		bi = int'(b);
		vmax = (ri > gi) ? ri : gi;
		vmax = (vmax > bi) ? vmax : bi;
		vmin = (ri < gi) ? ri : gi;
		vmin = (vmin < bi) ? vmin : bi;
		d = vmax - vmin;
		w.hue = '0;
		w.sat = '0;
		w.bright = vmax[7:0];
		w.last = last;
		if (vmax != 0)
			w.sat = Q_W'((4080 * d) / vmax);
		if (d != 0) begin
			// ties go red, then green, then blue
			if (vmax == ri)
				num = 480 * (gi - bi);
			else if (vmax == gi)
				num = 960 * d + 480 * (bi - ri);
			else
				num = 1920 * d + 480 * (ri - gi);
			if (num < 0)
				num += 2880 * d;
			w.hue = Q_W'(num / d);
		end
		// limits compare against truncated Q8.4, so registers scale by 16
		w.keep = int'(w.hue) >= lim_hue_min * 16 && int'(w.hue) <= lim_hue_max * 16 &&
			int'(w.sat) >= lim_sat_min * 16 && int'(w.sat) <= lim_sat_max * 16;
		return w;
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	// Drive one pixel at the falling edge, hold until taken, log its expected word.
	task automatic push_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
			input logic last, input hsv_word_t want);
		while (!calm && $urandom_range(99) < 24) begin
			pix_bus.valid <= 1'b0;
			@(negedge clk);
		end
		pix_bus.valid <= 1'b1;
		pix_bus.red <= r;
		pix_bus.green <= g;
		pix_bus.blue <= b;
		pix_bus.last_of_cloud <= last;
		@(posedge clk);
		while (!pix_bus.ready)
			@(posedge clk);
		pending_hsv = {pending_hsv, want};
		@(negedge clk);
	endtask

	// Random pixel, biased toward grays, ties and small channel spreads.
	task automatic random_pixel();
		logic [7:0] r, g, b, base;
		logic last;
		int pick;
		pick = $urandom_range(99);
		r = 8'($urandom);
		g = 8'($urandom);
		b = 8'($urandom);
		if (pick < 10) begin
			g = r;
			b = r;
		end else if (pick < 25) begin
			case ($urandom_range(2))
				0: g = r;
				1: b = g;
				default: b = r;
			endcase
		end else if (pick < 40) begin
			base = 8'($urandom_range(252));
			r = base + 8'($urandom_range(3));
			g = base + 8'($urandom_range(3));
			b = base + 8'($urandom_range(3));
		end
		last = ($urandom_range(9) == 0);
		push_pixel(r, g, b, last, predict_hsv(r, g, b, last));
	endtask

	// Let the pipeline empty out before touching the limits.
	task automatic drain_results();
		pix_bus.valid <= 1'b0;
		while (pending_hsv.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic set_limit(input logic [1:0] idx, input int val);
		cfg_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CH_W'(val);
		@(negedge clk);
		cfg_en <= 1'b0;
		case (idx)
			CFG_HUE_MIN: lim_hue_min = val;
			CFG_HUE_MAX: lim_hue_max = val;
			CFG_SAT_MIN: lim_sat_min = val;
			CFG_SAT_MAX: lim_sat_max = val;
			default: ;
		endcase
	endtask

	task automatic set_window(input int hmin, input int hmax, input int smin, input int smax);
		drain_results();
		set_limit(CFG_HUE_MIN, hmin);
		set_limit(CFG_HUE_MAX, hmax);
		set_limit(CFG_SAT_MIN, smin);
		set_limit(CFG_SAT_MAX, smax);
	endtask

	// Sink side: stall about a quarter of the time unless in the calm phase.
	always @(negedge clk) begin
		hsv_bus.ready <= calm || $urandom_range(99) >= 24;
	end

	// Checker: every hsv word taken is matched against the oldest expectation.
	always @(posedge clk) begin : hsv_monitor
		hsv_word_t want;
		if (arst_n && hsv_bus.valid && hsv_bus.ready) begin
			if (pending_hsv.size() == 0) begin
				$error("hsv word with nothing expected: hue %0d sat %0d",
					hsv_bus.hue, hsv_bus.saturation);
				fail_count++;
			end else begin
				want = pending_hsv.pop_front();
				check_field("hue", want.hue, hsv_bus.hue);
				check_field("saturation", want.sat, hsv_bus.saturation);
				check_field("brightness", want.bright, hsv_bus.brightness);
				check_field("keep", want.keep, hsv_bus.keep);
				check_field("last_out", want.last, hsv_bus.last_out);
			end
		end
	end

	// Watchdog: trips when no word moves on either channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (pix_bus.valid && pix_bus.ready) || (hsv_bus.valid && hsv_bus.ready))
			stall_count <= 0;
		else
			stall_count <= stall_count + 1;
		if (stall_count >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin : stimulus
		hsv_word_t want;
		pixel_case_t row;
		int hmin, hmax, smin, smax;

		arst_n = 1'b0;
		cfg_en = 1'b0;
		cfg_index = CFG_HUE_MIN;
		cfg_data = '0;
		pix_bus.valid = 1'b0;
		pix_bus.red = '0;
		pix_bus.green = '0;
		pix_bus.blue = '0;
		pix_bus.last_of_cloud = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed rows at the reset window
		for (int i = 0; i < N_DIRECTED; i++) begin
			row = directed_cases[i];
			if (row.typed)
				want = '{hue: row.hue, sat: row.sat, bright: row.bright,
					keep: row.keep, last: row.last};
			else
				want = predict_hsv(row.r, row.g, row.b, row.last);
			push_pixel(row.r, row.g, row.b, row.last, want);
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: ;                                 // reset window
				1: set_window(0, 180, 0, 255);       // everything kept
				2: set_window(0, 0, 0, 0);           // lowest extremes
				3: set_window(180, 180, 255, 255);   // highest extremes
				4: set_window(255, 255, 255, 255);   // hue limits past 180
				5: set_window(120, 60, 200, 100);    // empty window
				default: begin
					hmin = $urandom_range(180);
					hmax = $urandom_range(180, hmin);
					smin = $urandom_range(255);
					smax = $urandom_range(255, smin);
					set_window(hmin, hmax, smin, smax);
				end
			endcase
			calm = (phase == 6);  // one long stretch at full rate both sides
			for (int n = 0; n < PER_PHASE; n++)
				random_pixel();
		end

		drain_results();
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
